// ----- src/usst_pkg.sv -----
// ----------------------------------------------------------------------------
// usst_pkg
// Shared constants, codes and types of the UDP socket slot table.
// ----------------------------------------------------------------------------
package usst_pkg;

	localparam int SOCKET_SLOTS = 16;
	localparam int IDX_W = (SOCKET_SLOTS > 1) ? $clog2(SOCKET_SLOTS) : 1;
	localparam int CNT_W = $clog2(SOCKET_SLOTS + 1);

	localparam logic [15:0] EPHEMERAL_BASE  = 16'd49152;
	localparam logic [15:0] EPHEMERAL_LAST  = 16'hFFFF;
	localparam logic [15:0] UDP_HDR_BYTES   = 16'd8;
	localparam logic [15:0] PAYLOAD_CEILING = 16'd65527;

	localparam logic [15:0] RST_FAMILY  = 16'd2;
	localparam logic [15:0] RST_DGRAM   = 16'd2;
	localparam logic [15:0] RST_MAX_PAY = 16'd1472;

	typedef enum logic [1:0] {
		REQ_CREATE = 2'd0,
		REQ_BIND   = 2'd1,
		REQ_SEND   = 2'd2,
		REQ_CLOSE  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_FAMILY  = 3'd1,
		ST_BAD_TYPE    = 3'd2,
		ST_NO_SLOT     = 3'd3,
		ST_BAD_SOCKET  = 3'd4,
		ST_PORT_IN_USE = 3'd5,
		ST_BAD_LENGTH  = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		CFG_FAMILY_STD = 3'd0,
		CFG_FAMILY_ALT = 3'd1,
		CFG_DGRAM_STD  = 3'd2,
		CFG_DGRAM_ALT  = 3'd3,
		CFG_MAX_PAY    = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [31:0] local_ip;
		logic [15:0] own_port;
		logic [31:0] target_ip;
		logic [15:0] peer_port;
	} slot_entry_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  sock;
		logic [31:0] src_ip;
		logic [15:0] source_port;
		logic [31:0] dst_ip;
		logic [15:0] dst_port;
		logic [15:0] datagram_length;
	} result_t;

	function automatic result_t make_error(status_t st, logic [7:0] sock);
		result_t r;
		r = '0;
		r.status = st;
		r.sock = sock;
		return r;
	endfunction

	function automatic result_t make_report(status_t st, logic [7:0] sock, slot_entry_t e,
			logic [15:0] ulen);
		result_t r;
		r.status = st;
		r.sock = sock;
		r.src_ip = e.local_ip;
		r.source_port = e.own_port;
		r.dst_ip = e.target_ip;
		r.dst_port = e.peer_port;
		r.datagram_length = ulen;
		return r;
	endfunction

endpackage

// ----- src/udp_socket_slot_table.sv -----
// ----------------------------------------------------------------------------
// udp_socket_slot_table
// Socket slot table serving create, bind, send and close requests.
// ----------------------------------------------------------------------------
// states to the result register: close and early rejects check, done; send
// check, modify, done; create check, linear free-slot search, alloc, done;
// bind check, port scan through the single read port of the entry memory,
// modify, done; one item at a time, next taken the cycle after the result loads
// reset: valid and bound marks cleared at once, ephemeral port 49152,
// config registers to their defaults; the entry memory is not cleared
module udp_socket_slot_table (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  socket_id,
	input  logic [15:0] addr_family,
	input  logic [15:0] socket_kind,
	input  logic [31:0] addr_ip,
	input  logic [15:0] addr_port,
	input  logic [15:0] payload_length,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  result_socket,
	output logic [31:0] src_ip,
	output logic [15:0] source_port,
	output logic [31:0] dst_ip,
	output logic [15:0] dst_port,
	output logic [15:0] datagram_length,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_FREE_SCAN,
		S_ALLOC,
		S_PORT_SCAN,
		S_MODIFY,
		S_DONE
	} state_t;

	localparam int SLOTS = usst_pkg::SOCKET_SLOTS;
	localparam int IW = usst_pkg::IDX_W;
	localparam int CW = usst_pkg::CNT_W;

	state_t state_q;

	logic [15:0] fam_std_q, fam_alt_q, dg_std_q, dg_alt_q, max_pay_q;
	logic [15:0] eph_q;
	logic [SLOTS-1:0] valid_q, bound_q;

	// latched request
	usst_pkg::req_t req_q;
	logic [7:0]  slot_q;
	logic [15:0] fam_q, kind_q, port_q, len_q;
	logic [31:0] ip_q;

	logic [CW-1:0] scan_q;
	logic          pend_s1;
	logic          live_s1;

	usst_pkg::result_t res_q, out_q;
	logic out_valid_q;

	// entry memory
	usst_pkg::slot_entry_t mem [SLOTS];
	usst_pkg::slot_entry_t rd_data_s1;
	usst_pkg::slot_entry_t wr_data;
	logic [IW-1:0] rd_addr;
	logic          wr_en;

	logic [IW-1:0] slot_idx;
	logic [IW-1:0] scan_idx;
	logic          id_live;
	logic          len_bad;
	logic          out_free;
	logic          scan_end;
	logic          conflict;

	assign slot_idx = slot_q[IW-1:0];
	assign scan_idx = scan_q[IW-1:0];
	assign scan_end = (scan_q == CW'(SLOTS));
	assign id_live  = ({1'b0, slot_q} < 9'(SLOTS)) && valid_q[slot_idx];
	assign len_bad  = (len_q == 16'd0) || (len_q > max_pay_q)
		|| (len_q > usst_pkg::PAYLOAD_CEILING);
	assign conflict = pend_s1 && live_s1 && (rd_data_s1.own_port == port_q);
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// port scan walks the slots, then fetches the addressed slot
	always_comb begin
		if (state_q == S_PORT_SCAN && !scan_end) begin
			rd_addr = scan_idx;
		end else begin
			rd_addr = slot_idx;
		end
	end

	always_comb begin
		wr_en = 1'b0;
		wr_data = rd_data_s1;
		if (state_q == S_ALLOC) begin
			wr_en = 1'b1;
			wr_data = '0;
			wr_data.own_port = eph_q;
		end else if (state_q == S_MODIFY) begin
			wr_en = 1'b1;
			if (req_q == usst_pkg::REQ_BIND) begin
				wr_data.local_ip = ip_q;
				wr_data.own_port = port_q;
			end else begin
				wr_data.target_ip = ip_q;
				wr_data.peer_port = port_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot_idx] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fam_std_q <= usst_pkg::RST_FAMILY;
			fam_alt_q <= usst_pkg::RST_FAMILY;
			dg_std_q  <= usst_pkg::RST_DGRAM;
			dg_alt_q  <= usst_pkg::RST_DGRAM;
			max_pay_q <= usst_pkg::RST_MAX_PAY;
		end else if (cfg_valid && cfg_ready) begin
			case (usst_pkg::cfg_idx_t'(cfg_index))
				usst_pkg::CFG_FAMILY_STD: fam_std_q <= cfg_data;
				usst_pkg::CFG_FAMILY_ALT: fam_alt_q <= cfg_data;
				usst_pkg::CFG_DGRAM_STD:  dg_std_q <= cfg_data;
				usst_pkg::CFG_DGRAM_ALT:  dg_alt_q <= cfg_data;
				usst_pkg::CFG_MAX_PAY:    max_pay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request latch, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_q  <= usst_pkg::req_t'(req_type);
			fam_q  <= addr_family;
			kind_q <= socket_kind;
			ip_q   <= addr_ip;
			port_q <= addr_port;
			len_q  <= payload_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			bound_q     <= '0;
			eph_q       <= usst_pkg::EPHEMERAL_BASE;
			slot_q      <= '0;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			live_s1     <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// the done state reloads the result register itself
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						slot_q  <= socket_id;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					scan_q  <= '0;
					pend_s1 <= 1'b0;
					if (req_q == usst_pkg::REQ_CREATE) begin
						if (fam_q != fam_std_q && fam_q != fam_alt_q) begin
							res_q   <= usst_pkg::make_error(usst_pkg::ST_BAD_FAMILY, 8'd0);
							state_q <= S_DONE;
						end else if (kind_q != dg_std_q && kind_q != dg_alt_q) begin
							res_q   <= usst_pkg::make_error(usst_pkg::ST_BAD_TYPE, 8'd0);
							state_q <= S_DONE;
						end else begin
							state_q <= S_FREE_SCAN;
						end
					end else if (!id_live) begin
						res_q   <= usst_pkg::make_error(usst_pkg::ST_BAD_SOCKET, slot_q);
						state_q <= S_DONE;
					end else begin
						case (req_q)
							usst_pkg::REQ_CLOSE: begin
								valid_q[slot_idx] <= 1'b0;
								bound_q[slot_idx] <= 1'b0;
								res_q   <= usst_pkg::make_error(usst_pkg::ST_OK, slot_q);
								state_q <= S_DONE;
							end
							usst_pkg::REQ_SEND: begin
								if (len_bad) begin
									res_q   <= usst_pkg::make_error(usst_pkg::ST_BAD_LENGTH,
										slot_q);
									state_q <= S_DONE;
								end else begin
									// entry read issued at this edge
									state_q <= S_MODIFY;
								end
							end
							default: begin
								state_q <= S_PORT_SCAN;
							end
						endcase
					end
				end
				S_FREE_SCAN: begin
					if (!valid_q[scan_idx]) begin
						slot_q  <= 8'(scan_idx);
						state_q <= S_ALLOC;
					end else if (scan_q == CW'(SLOTS - 1)) begin
						res_q   <= usst_pkg::make_error(usst_pkg::ST_NO_SLOT, 8'd0);
						state_q <= S_DONE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_ALLOC: begin
					valid_q[slot_idx] <= 1'b1;
					bound_q[slot_idx] <= 1'b0;
					res_q   <= usst_pkg::make_report(usst_pkg::ST_OK, slot_q, wr_data, 16'd0);
					eph_q   <= (eph_q == usst_pkg::EPHEMERAL_LAST) ?
						usst_pkg::EPHEMERAL_BASE : eph_q + 16'd1;
					state_q <= S_DONE;
				end
				S_PORT_SCAN: begin
					// only other valid, bound slots can hold the port
					pend_s1 <= !scan_end;
					live_s1 <= !scan_end && valid_q[scan_idx] && bound_q[scan_idx]
						&& (scan_idx != slot_idx);
					if (conflict) begin
						res_q   <= usst_pkg::make_error(usst_pkg::ST_PORT_IN_USE, slot_q);
						state_q <= S_DONE;
					end else if (scan_end) begin
						state_q <= S_MODIFY;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_MODIFY: begin
					if (req_q == usst_pkg::REQ_BIND) begin
						bound_q[slot_idx] <= 1'b1;
						res_q <= usst_pkg::make_report(usst_pkg::ST_OK, slot_q, wr_data, 16'd0);
					end else begin
						res_q <= usst_pkg::make_report(usst_pkg::ST_OK, slot_q, wr_data,
							len_q + usst_pkg::UDP_HDR_BYTES);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign result_socket   = out_q.sock;
	assign src_ip          = out_q.src_ip;
	assign source_port     = out_q.source_port;
	assign dst_ip          = out_q.dst_ip;
	assign dst_port        = out_q.dst_port;
	assign datagram_length = out_q.datagram_length;

endmodule
